@@ sv/sliding_window_min_max_top_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef SLIDING_WINDOW_MIN_MAX_TOP_MACROS_SVH
`define SLIDING_WINDOW_MIN_MAX_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define SWMM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SWMM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SWMM_ASSERT(name, prop, msg)
`define SWMM_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

@@ sv/swmm_pkg.sv @@
package swmm_pkg;

  localparam int unsigned SampleW      = 12;
  localparam int unsigned VoltW        = 16;
  localparam int unsigned ProdW        = SampleW + VoltW;
  localparam int unsigned DenShift     = 12;
  localparam int unsigned ConvLat      = 3;
  localparam int unsigned DepthDefault = 10;

  localparam logic [VoltW-1:0]   VoltNum   = 16'd33000;
  localparam logic [ProdW-1:0]   VoltDen   = 28'd4095;
  localparam logic [SampleW-1:0] SampleMax = 12'hFFF;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_CONV = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

@@ sv/swmm_cell.sv @@
module swmm_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swmm_pkg::cell_ctrl_t          ctrl_i,
  input  logic [swmm_pkg::SampleW-1:0]  data_i,
  input  logic [swmm_pkg::SampleW-1:0]  lo_i,
  input  logic [swmm_pkg::SampleW-1:0]  hi_i,
  output logic [swmm_pkg::SampleW-1:0]  entry_o,
  output logic [swmm_pkg::SampleW-1:0]  lo_o,
  output logic [swmm_pkg::SampleW-1:0]  hi_o
);

  logic [swmm_pkg::SampleW-1:0] entry_q, entry_d;
  logic [swmm_pkg::SampleW-1:0] lo_q, lo_d, hi_q, hi_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = ctrl_i.clear ? '0 : data_i;
    end
    lo_d = (entry_q < lo_i) ? entry_q : lo_i;
    hi_d = (entry_q > hi_i) ? entry_q : hi_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
  end

  assign entry_o = entry_q;
  assign lo_o    = lo_q;
  assign hi_o    = hi_q;

endmodule

@@ sv/swmm_conv.sv @@
module swmm_conv (
  input  logic                         clk_i,
  input  logic [swmm_pkg::SampleW-1:0] raw_i,
  output logic [swmm_pkg::VoltW-1:0]   volts_o
);

  logic [swmm_pkg::ProdW-1:0] prod_q, prod_d, prod2_q;
  logic [swmm_pkg::ProdW:0]   sum;
  logic [swmm_pkg::VoltW-1:0] quot_q, quot_d;
  logic [swmm_pkg::ProdW-1:0] rem;
  logic [swmm_pkg::VoltW-1:0] volts_q, volts_d;

  // The divide by 4095 uses 1/(4096-1) as a short geometric series; the
  // estimate is at most one low and a single compare fixes it.
  always_comb begin
    prod_d  = swmm_pkg::ProdW'(raw_i) * swmm_pkg::ProdW'(swmm_pkg::VoltNum);
    sum     = (swmm_pkg::ProdW+1)'(prod_q)
            + (swmm_pkg::ProdW+1)'(prod_q >> swmm_pkg::DenShift)
            + (swmm_pkg::ProdW+1)'(prod_q >> (2 * swmm_pkg::DenShift));
    quot_d  = swmm_pkg::VoltW'(sum >> swmm_pkg::DenShift);
    rem     = prod2_q - (swmm_pkg::ProdW'(quot_q) << swmm_pkg::DenShift)
            + swmm_pkg::ProdW'(quot_q);
    volts_d = (rem >= swmm_pkg::VoltDen) ? quot_q + 1'b1 : quot_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    prod2_q <= prod_q;
    quot_q  <= quot_d;
    volts_q <= volts_d;
  end

  assign volts_o = volts_q;

endmodule

@@ sv/sliding_window_min_max_top.sv @@
// Sliding window minimum and maximum tracker for 12-bit ADC samples.
// The input channel takes one word per sample: tdata carries the sample and
// tuser the command, where a high command clears the window before the
// sample is pushed. The output channel gives one word per input word with
// the window minimum and maximum, and the sample, minimum and maximum
// converted to units of 0.1 mV.
// The window is a row of WINDOW_DEPTH cells. An accepted sample shifts in
// at the first cell; the running minimum and maximum then move one cell per
// cycle down the row. The conversion pipeline follows, and the result is
// then loaded into the output register once that register is free.
// The block takes no new sample until the previous one has been scanned,
// converted and loaded into the output register.
// A new sample is taken while an earlier result still waits in the output
// register; a stalled receiver holds the next result back until that word
// is taken. Reset clears the window to zeros and empties the output.
`include "sliding_window_min_max_top_macros.svh"

module sliding_window_min_max_top #(
  parameter int unsigned WINDOW_DEPTH = swmm_pkg::DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [11:0] sample, [15:12] zero
  input  logic        s_axis_tuser,  // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] sample_volts, [27:16] window_min, [39:28] window_max,
  // [55:40] min_volts, [71:56] max_volts
  output logic [71:0] m_axis_tdata
);

  localparam int unsigned CntMax = (WINDOW_DEPTH > swmm_pkg::ConvLat) ?
                                   WINDOW_DEPTH : swmm_pkg::ConvLat;
  localparam int unsigned CntW   = $clog2(CntMax);

  swmm_pkg::state_e state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_vld_q, out_vld_d;
  logic [71:0]      out_data_q, out_data_d;
  logic [swmm_pkg::SampleW-1:0] sample_q, sample_d;

  logic in_acc, out_acc, load_out;
  swmm_pkg::cell_ctrl_t head_ctrl, tail_ctrl;

  logic [swmm_pkg::SampleW-1:0] entry [WINDOW_DEPTH];
  logic [swmm_pkg::SampleW-1:0] lo    [WINDOW_DEPTH];
  logic [swmm_pkg::SampleW-1:0] hi    [WINDOW_DEPTH];

  logic [swmm_pkg::VoltW-1:0] sample_volts, min_volts, max_volts;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  assign head_ctrl = '{shift: in_acc, clear: 1'b0};
  assign tail_ctrl = '{shift: in_acc, clear: s_axis_tuser};

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (head_ctrl),
        .data_i  (s_axis_tdata[swmm_pkg::SampleW-1:0]),
        .lo_i    (swmm_pkg::SampleMax),
        .hi_i    ('0),
        .entry_o (entry[i]),
        .lo_o    (lo[i]),
        .hi_o    (hi[i])
      );
    end else begin : g_body
      swmm_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (tail_ctrl),
        .data_i  (entry[i-1]),
        .lo_i    (lo[i-1]),
        .hi_i    (hi[i-1]),
        .entry_o (entry[i]),
        .lo_o    (lo[i]),
        .hi_o    (hi[i])
      );
    end
  end

  swmm_conv u_conv_sample (
    .clk_i   (clk_i),
    .raw_i   (sample_q),
    .volts_o (sample_volts)
  );

  swmm_conv u_conv_min (
    .clk_i   (clk_i),
    .raw_i   (lo[WINDOW_DEPTH-1]),
    .volts_o (min_volts)
  );

  swmm_conv u_conv_max (
    .clk_i   (clk_i),
    .raw_i   (hi[WINDOW_DEPTH-1]),
    .volts_o (max_volts)
  );

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sample_d   = sample_q;
    load_out   = 1'b0;
    s_axis_tready = (state_q == swmm_pkg::ST_IDLE);
    case (state_q)
      swmm_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d  = swmm_pkg::ST_SCAN;
          cnt_d    = '0;
          sample_d = s_axis_tdata[swmm_pkg::SampleW-1:0];
        end
      end
      swmm_pkg::ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(WINDOW_DEPTH - 1)) begin
          state_d = swmm_pkg::ST_CONV;
          cnt_d   = '0;
        end
      end
      swmm_pkg::ST_CONV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(swmm_pkg::ConvLat - 1)) begin
          state_d = swmm_pkg::ST_DONE;
          cnt_d   = '0;
        end
      end
      swmm_pkg::ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = swmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swmm_pkg::ST_IDLE;
      end
    endcase

    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (out_acc) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d  = 1'b1;
      out_data_d = {max_volts, min_volts, hi[WINDOW_DEPTH-1], lo[WINDOW_DEPTH-1],
                    sample_volts};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swmm_pkg::ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  `SWMM_ASSERT(a_accept_starts_scan, in_acc |=> (state_q == swmm_pkg::ST_SCAN), "accept did not start a scan")
  `SWMM_ASSERT(a_no_overwrite, (state_q == swmm_pkg::ST_DONE && out_vld_q && !m_axis_tready) |=> (state_q == swmm_pkg::ST_DONE), "pending result was overwritten")
  `SWMM_ASSERT(a_min_le_max, out_vld_q |-> (out_data_q[27:16] <= out_data_q[39:28]), "window minimum above maximum")
  `SWMM_ASSERT(a_scan_count, (state_q == swmm_pkg::ST_SCAN) |-> (cnt_q <= CntW'(WINDOW_DEPTH - 1)), "scan count out of range")
  `SWMM_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == swmm_pkg::ST_IDLE && !out_vld_q), "reset did not clear control state")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DEPTH = swmm_pkg::DepthDefault;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned RANDOM_WORDS = 1350;

  typedef struct packed {
    logic [15:0] max_volts;
    logic [15:0] min_volts;
    logic [11:0] window_max;
    logic [11:0] window_min;
    logic [15:0] sample_volts;
  } result_t;

  typedef struct packed {
    logic        clear;
    logic [11:0] sample;
    logic        typed;
    result_t     expected;
  } row_t;

  localparam result_t ALL_ZERO = '0;
  localparam result_t PEAK_PARTIAL = '{max_volts: 16'd33000, min_volts: 16'd0,
                                       window_max: 12'd4095, window_min: 12'd0,
                                       sample_volts: 16'd33000};
  localparam result_t PEAK_FULL = '{max_volts: 16'd33000, min_volts: 16'd33000,
                                    window_max: 12'd4095, window_min: 12'd4095,
                                    sample_volts: 16'd33000};

  localparam int unsigned NUM_ROWS = 22;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b1, 12'd0,    1'b1, ALL_ZERO},
    '{1'b1, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_PARTIAL},
    '{1'b0, 12'd4095, 1'b1, PEAK_FULL},
    '{1'b0, 12'd1,    1'b0, ALL_ZERO},
    '{1'b0, 12'd0,    1'b0, ALL_ZERO},
    '{1'b0, 12'd2048, 1'b0, ALL_ZERO},
    '{1'b0, 12'h555,  1'b0, ALL_ZERO},
    '{1'b0, 12'hAAA,  1'b0, ALL_ZERO},
    '{1'b0, 12'd4094, 1'b0, ALL_ZERO},
    '{1'b1, 12'h800,  1'b0, ALL_ZERO},
    '{1'b0, 12'h7FF,  1'b0, ALL_ZERO},
    '{1'b0, 12'h001,  1'b0, ALL_ZERO},
    '{1'b1, 12'd4095, 1'b0, ALL_ZERO}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;

  logic [11:0] window_vals [DEPTH];
  int unsigned window_fill;
  result_t     pending_results [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned quiet_cycles;

  sliding_window_min_max_top #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [15:0] to_tenth_mv(logic [11:0] raw);
    int unsigned scaled;
    scaled = (int'(raw) * 33000) / 4095;
    return scaled[15:0];
  endfunction

  // Both sides go without stalls for a stretch in the middle of the run.
  function automatic bit idle_now();
    bit calm;
    calm = (cycle_count >= 8000) && (cycle_count < 14000);
    return !calm && ($urandom_range(99) < 18);
  endfunction

  function automatic result_t track_window(logic clear, logic [11:0] sample);
    result_t     res;
    logic [11:0] lo;
    logic [11:0] hi;
    if (clear) begin
      foreach (window_vals[i]) window_vals[i] = '0;
      window_fill = 0;
    end
    if (window_fill < DEPTH) begin
      window_vals[window_fill] = sample;
      window_fill++;
    end else begin
      for (int i = 0; i < DEPTH - 1; i++) window_vals[i] = window_vals[i+1];
      window_vals[DEPTH-1] = sample;
    end
    lo = 12'hFFF;
    hi = 12'h000;
    foreach (window_vals[i]) begin
      if (window_vals[i] < lo) lo = window_vals[i];
      if (window_vals[i] > hi) hi = window_vals[i];
    end
    res.sample_volts = to_tenth_mv(sample);
    res.window_min   = lo;
    res.window_max   = hi;
    res.min_volts    = to_tenth_mv(lo);
    res.max_volts    = to_tenth_mv(hi);
    return res;
  endfunction

  task automatic send_word(logic clear, logic [11:0] sample, logic typed, result_t typed_res);
    result_t predicted;
    @(negedge clk_i);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, sample};
    s_axis_tuser  <= clear;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = track_window(clear, sample);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic compare_field(string name, int unsigned exp_val, int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= !idle_now();
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    cycle_count++;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("sample_volts", want.sample_volts, got.sample_volts);
        compare_field("window_min", want.window_min, got.window_min);
        compare_field("window_max", want.window_max, got.window_max);
        compare_field("min_volts", want.min_volts, got.min_volts);
        compare_field("max_volts", want.max_volts, got.max_volts);
      end
    end
  end

  initial begin
    logic [11:0] sample;
    logic        clear;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    quiet_cycles   = 0;
    window_fill    = 0;
    foreach (window_vals[i]) window_vals[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].clear, DIRECTED[i].sample, DIRECTED[i].typed,
                DIRECTED[i].expected);
    end

    // Clears are rare so that the window usually fills and starts dropping
    // its oldest entries.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      clear = ($urandom_range(99) < 4);
      case ($urandom_range(9))
        0: sample = 12'd0;
        1: sample = 12'd4095;
        default: sample = 12'($urandom_range(4095));
      endcase
      send_word(clear, sample, 1'b0, ALL_ZERO);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/swmm_pkg.sv
sv/swmm_cell.sv
sv/swmm_conv.sv
sv/sliding_window_min_max_top.sv
verif/testbench.sv
